// ===== rtl/klbt_pkg.sv =====
// shared constants and controller/datapath interface types for the transposition core
`default_nettype none

package klbt_pkg;

	localparam int unsigned KEY_MAX_DEF = 8;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS  = 1'b1;

	localparam int unsigned KEY_LEN_W   = 4;
	localparam int unsigned KEY_CHARS_W = 64;
	localparam int unsigned CHAR_W      = 8;

	localparam logic [KEY_LEN_W-1:0]   KEY_LEN_RST   = 4'd1;
	localparam logic [KEY_CHARS_W-1:0] KEY_CHARS_RST = 64'd65;

	// letter bounds, exclusive
	localparam logic [CHAR_W-1:0] UPPER_LO = 8'd64;
	localparam logic [CHAR_W-1:0] UPPER_HI = 8'd91;
	localparam logic [CHAR_W-1:0] LOWER_LO = 8'd96;
	localparam logic [CHAR_W-1:0] LOWER_HI = 8'd123;

	localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h58;

	localparam int unsigned DEDUP_ROUNDS = 4096;
	localparam int unsigned RND_W        = $clog2(DEDUP_ROUNDS);

	typedef struct packed {
		logic accept;
		logic start_order;
		logic dedup_step;
		logic sort_step;
		logic load_beat;
	} klbt_cmd_t;

	typedef struct packed {
		logic emit_now;
		logic order_ready;
		logic dedup_done;
		logic sort_last;
		logic emit_last;
		logic out_free;
	} klbt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/klbt_dp.sv =====
// datapath: key registers, block store, key ordering unit and output register
`default_nettype none

module klbt_dp #(
	parameter int unsigned KEY_MAX = klbt_pkg::KEY_MAX_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [klbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [klbt_pkg::KEY_CHARS_W-1:0]    cfg_data,
	input  wire logic [klbt_pkg::CHAR_W-1:0]         text_char,
	input  wire logic                                end_of_message,
	input  wire klbt_pkg::klbt_cmd_t                 cmd,
	output klbt_pkg::klbt_sts_t                      sts,
	input  wire logic                                out_stall,
	output logic                                     out_valid,
	output logic [klbt_pkg::CHAR_W-1:0]              out_char,
	output logic                                     last_of_block,
	output logic                                     last_of_message
);
	import klbt_pkg::*;

	localparam int unsigned IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int unsigned CNT_W = $clog2(KEY_MAX + 1);

	logic [KEY_LEN_W-1:0]   key_length_q;
	logic [KEY_CHARS_W-1:0] key_chars_q;
	logic [CNT_W-1:0]       fill_q;
	logic                   order_ready_q;
	logic                   out_valid_q;

	logic [CHAR_W-1:0] store_q [KEY_MAX];
	logic [CHAR_W-1:0] wk_q [KEY_MAX];
	logic [IDX_W-1:0]  order_q [KEY_MAX];
	logic [KEY_MAX-1:0] used_q;
	logic [RND_W-1:0]  round_q;
	logic [IDX_W-1:0]  sort_idx_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  emit_fill_q;
	logic              eom_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              last_blk_q;
	logic              last_msg_q;

	logic [CNT_W-1:0]   n_len;
	logic [CNT_W-1:0]   n_last;
	logic [CNT_W-1:0]   fill_inc;
	logic               is_letter;
	logic               emit_now;
	logic [KEY_MAX-1:0] in_len;
	logic [KEY_MAX-1:0] dup_flag;
	logic               dup_found;
	logic [IDX_W-1:0]   dup_sel;
	logic               have;
	logic [IDX_W-1:0]   best;
	logic [CHAR_W-1:0]  best_k;
	logic [IDX_W-1:0]   rd_idx;
	logic [CHAR_W-1:0]  beat_char;
	logic               beat_last;

	// effective block length: zero acts as one, large values saturate
	always_comb begin
		if (key_length_q == '0) begin
			n_len = CNT_W'(1);
		end else if (key_length_q > KEY_LEN_W'(KEY_MAX)) begin
			n_len = CNT_W'(KEY_MAX);
		end else begin
			n_len = CNT_W'(key_length_q);
		end
	end

	assign n_last   = n_len - CNT_W'(1);
	assign fill_inc = fill_q + CNT_W'(1);

	assign is_letter = (text_char > UPPER_LO && text_char < UPPER_HI) ||
		(text_char > LOWER_LO && text_char < LOWER_HI);

	assign emit_now = (is_letter && fill_inc >= n_len) ||
		(end_of_message && (is_letter || fill_q != '0));

	always_comb begin
		for (int i = 0; i < KEY_MAX; i++) begin
			in_len[i] = CNT_W'(i) < n_len;
		end
	end

	// a key character is a duplicate when another in-use character matches it
	always_comb begin
		for (int i = 0; i < KEY_MAX; i++) begin
			dup_flag[i] = 1'b0;
			for (int j = 0; j < KEY_MAX; j++) begin
				if (j != i && in_len[j] && wk_q[j] == wk_q[i]) begin
					dup_flag[i] = in_len[i];
				end
			end
		end
	end

	// lowest-indexed duplicate wins
	always_comb begin
		dup_found = 1'b0;
		dup_sel   = '0;
		for (int i = KEY_MAX - 1; i >= 0; i--) begin
			if (dup_flag[i]) begin
				dup_found = 1'b1;
				dup_sel   = IDX_W'(i);
			end
		end
	end

	// smallest unused key character, ties go to the lower index
	always_comb begin
		have   = 1'b0;
		best   = '0;
		best_k = '0;
		for (int i = 0; i < KEY_MAX; i++) begin
			if (in_len[i] && !used_q[i] && (!have || wk_q[i] < best_k)) begin
				have   = 1'b1;
				best   = IDX_W'(i);
				best_k = wk_q[i];
			end
		end
	end

	assign rd_idx    = order_q[ptr_q];
	assign beat_char = (CNT_W'(rd_idx) < emit_fill_q) ? store_q[rd_idx] : PAD_CHAR;
	assign beat_last = CNT_W'(ptr_q) == n_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q  <= KEY_LEN_RST;
			key_chars_q   <= KEY_CHARS_RST;
			fill_q        <= '0;
			order_ready_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LENGTH: begin
						key_length_q <= cfg_data[KEY_LEN_W-1:0];
					end
					CFG_KEY_CHARS: begin
						key_chars_q <= cfg_data;
					end
					default: begin
					end
				endcase
				order_ready_q <= 1'b0;
			end else if (cmd.sort_step && CNT_W'(sort_idx_q) == n_last) begin
				order_ready_q <= 1'b1;
			end
			if (cmd.accept) begin
				if (emit_now) begin
					fill_q <= '0;
				end else if (is_letter) begin
					fill_q <= fill_inc;
				end
			end
			if (cmd.load_beat) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_letter) begin
			store_q[fill_q[IDX_W-1:0]] <= text_char;
		end
		if (cmd.accept && emit_now) begin
			emit_fill_q <= is_letter ? fill_inc : fill_q;
			eom_q       <= end_of_message;
			ptr_q       <= '0;
		end
		if (cmd.start_order) begin
			for (int i = 0; i < KEY_MAX; i++) begin
				wk_q[i] <= key_chars_q[CHAR_W*i +: CHAR_W];
			end
			used_q     <= '0;
			round_q    <= '0;
			sort_idx_q <= '0;
		end
		if (cmd.dedup_step && dup_found) begin
			wk_q[dup_sel] <= wk_q[dup_sel] + CHAR_W'(1);
			round_q       <= round_q + RND_W'(1);
		end
		if (cmd.sort_step) begin
			order_q[sort_idx_q] <= best;
			used_q[best]        <= 1'b1;
			sort_idx_q          <= sort_idx_q + IDX_W'(1);
		end
		if (cmd.load_beat) begin
			out_char_q <= beat_char;
			last_blk_q <= beat_last;
			last_msg_q <= beat_last && eom_q;
			ptr_q      <= ptr_q + IDX_W'(1);
		end
	end

	assign sts.emit_now    = emit_now;
	assign sts.order_ready = order_ready_q;
	assign sts.dedup_done  = !dup_found || round_q == RND_W'(DEDUP_ROUNDS - 1);
	assign sts.sort_last   = CNT_W'(sort_idx_q) == n_last;
	assign sts.emit_last   = beat_last;
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign out_char        = out_char_q;
	assign last_of_block   = last_blk_q;
	assign last_of_message = last_msg_q;

endmodule

`default_nettype wire

// ===== rtl/klbt_ctrl.sv =====
// controller: sequences collection, key ordering and block emission
`default_nettype none

module klbt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire klbt_pkg::klbt_sts_t sts,
	output klbt_pkg::klbt_cmd_t      cmd
);
	import klbt_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DEDUP = 2'd1;
	localparam logic [1:0] ST_SORT  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		in_stall        = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && sts.emit_now) begin
					if (sts.order_ready) begin
						state_d = ST_EMIT;
					end else begin
						cmd.start_order = 1'b1;
						state_d         = ST_DEDUP;
					end
				end
			end
			ST_DEDUP: begin
				cmd.dedup_step = 1'b1;
				if (sts.dedup_done) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				cmd.sort_step = 1'b1;
				if (sts.sort_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.load_beat = sts.out_free;
				if (sts.out_free && sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/keyed_letter_block_transposition_core.sv =====
// Keyed letter block transposition core: letters of the byte stream are gathered into blocks
// of the block length (key_length, with zero taken as one and values above KEY_MAX as KEY_MAX)
// and each full block (or the X-padded remainder at end of message) is sent out
// reordered by ascending key character. A byte that completes no block is taken without a stall.
// A byte that completes a block holds the input stalled while the block's beats
// leave through the output register, one per cycle when the output is not stalled. The first
// block after reset or after any configuration write also orders the key first: duplicate key
// characters are incremented one at a time until they are unique or DEDUP_ROUNDS increments
// are done, then one key position is selected per block position, all in the shared
// ordering unit of the datapath. Later blocks reuse the stored order.
`default_nettype none

module keyed_letter_block_transposition_core #(
	parameter int unsigned KEY_MAX = klbt_pkg::KEY_MAX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [klbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [klbt_pkg::KEY_CHARS_W-1:0] cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [klbt_pkg::CHAR_W-1:0]      text_char,
	input  wire logic                             end_of_message,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [klbt_pkg::CHAR_W-1:0]           out_char,
	output logic                                  last_of_block,
	output logic                                  last_of_message
);
	import klbt_pkg::*;

	klbt_cmd_t cmd;
	klbt_sts_t sts;

	klbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	klbt_dp #(
		.KEY_MAX (KEY_MAX)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.text_char       (text_char),
		.end_of_message  (end_of_message),
		.cmd             (cmd),
		.sts             (sts),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.out_char        (out_char),
		.last_of_block   (last_of_block),
		.last_of_message (last_of_message)
	);

endmodule

`default_nettype wire
